### design/cpu_alu_flag_unit_defines.svh
// Assertion macros shared by the ALU and flag unit.
// No dependencies; included by the files that check their own logic.
`ifndef CPU_ALU_FLAG_UNIT_DEFINES_SVH
`define CPU_ALU_FLAG_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define CAF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define CAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/caf_pkg.sv
// Types, opcode codes and helper functions of the ALU and flag unit.
// No dependencies; used by the execute logic and the top level.
`timescale 1ns / 1ps

package caf_pkg;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] MASK_GROUP   = 8'hC7;
   localparam logic [7:0] MASK_PAIR    = 8'hCF;
   localparam logic [7:0] CODE_ALU_IMM = 8'hC6;
   localparam logic [7:0] CODE_INC     = 8'h04;
   localparam logic [7:0] CODE_DEC     = 8'h05;
   localparam logic [7:0] CODE_ADD_HL  = 8'h09;
   localparam logic [7:0] OP_ADD_SP    = 8'hE8;
   localparam logic [7:0] OP_LD_HL_SP  = 8'hF8;
   localparam logic [7:0] OP_DAA       = 8'h27;
   localparam logic [7:0] OP_CPL       = 8'h2F;
   localparam logic [7:0] OP_SCF       = 8'h37;
   localparam logic [7:0] OP_CCF       = 8'h3F;
   localparam logic [7:0] OP_RLCA      = 8'h07;
   localparam logic [7:0] OP_RRCA      = 8'h0F;
   localparam logic [7:0] OP_RLA       = 8'h17;
   localparam logic [7:0] OP_RRA       = 8'h1F;

   localparam logic [1:0] PAGE_ALU_REG = 2'b10;
   localparam logic [1:0] PAGE_LOW     = 2'b00;

   localparam logic [7:0]  DAA_LIMIT  = 8'h99;
   localparam logic [7:0]  DAA_HI_ADJ = 8'h60;
   localparam logic [7:0]  DAA_LO_ADJ = 8'h06;
   localparam logic [3:0]  DIGIT_MAX  = 4'h9;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC, ALU_AND, ALU_XOR, ALU_OR, ALU_CP
   } alu_op_type;

   typedef enum logic [2:0] {
      SH_RLC, SH_RRC, SH_RL, SH_RR, SH_SLA, SH_SRA, SH_SWAP, SH_SRL
   } shift_op_type;

   typedef enum logic [1:0] {
      CB_SHIFT, CB_BIT, CB_RES, CB_SET
   } cb_mode_type;

   typedef struct packed {
      logic [7:0]  opcode;
      logic        prefixed;
      logic [7:0]  acc;
      logic [7:0]  operand;
      logic [15:0] wide_a;
      logic [15:0] wide_b;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  result;
      logic [15:0] wide_result;
      logic [3:0]  flags_out;
      logic        writes_result;
      logic        supported;
   } rsp_type;

   // returns {carry out, shifted byte}
   function automatic logic [8:0] shift8(shift_op_type sel, logic [7:0] v, logic cin);
      logic [8:0] res;
      case (sel)
         SH_RLC:  res = {v[7], v[6:0], v[7]};
         SH_RRC:  res = {v[0], v[0], v[7:1]};
         SH_RL:   res = {v[7], v[6:0], cin};
         SH_RR:   res = {v[0], cin, v[7:1]};
         SH_SLA:  res = {v[7], v[6:0], 1'b0};
         SH_SRA:  res = {v[0], v[7], v[7:1]};
         SH_SWAP: res = {1'b0, v[3:0], v[7:4]};
         SH_SRL:  res = {v[0], 1'b0, v[7:1]};
         default: res = {1'b0, v};
      endcase
      return res;
   endfunction

endpackage

### design/caf_if.sv
// Request and response channels of the ALU and flag unit: valid, ready, payload.
// Depends on nothing but the widths of the package fields.
`timescale 1ns / 1ps

interface caf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode;
   logic        prefixed;
   logic [7:0]  acc;
   logic [7:0]  operand;
   logic [15:0] wide_a;
   logic [15:0] wide_b;
   logic [3:0]  flags_in;

   modport source (output valid, opcode, prefixed, acc, operand, wide_a, wide_b, flags_in,
                   input ready);
   modport sink (input valid, opcode, prefixed, acc, operand, wide_a, wide_b, flags_in,
                 output ready);
endinterface

interface caf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  result;
   logic [15:0] wide_result;
   logic [3:0]  flags_out;
   logic        writes_result;
   logic        supported;

   modport source (output valid, result, wide_result, flags_out, writes_result, supported,
                   input ready);
   modport sink (input valid, result, wide_result, flags_out, writes_result, supported,
                 output ready);
endinterface

### design/caf_exec.sv
// Opcode decode and datapath: one request beat in, one response beat out.
// Depends on caf_pkg.
`timescale 1ns / 1ps

module caf_exec (
   input  caf_pkg::req_type req,
   output caf_pkg::rsp_type rsp
);

   logic [7:0]  op;
   logic [7:0]  acc;
   logic [7:0]  opnd;
   logic        cin;
   logic        cuse;
   logic [8:0]  add9;
   logic [4:0]  addh5;
   logic [8:0]  sub9;
   logic [4:0]  subh5;
   logic [7:0]  and8;
   logic [7:0]  xor8;
   logic [7:0]  or8;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic [16:0] hl17;
   logic [12:0] hl13;
   logic [15:0] sp16;
   logic [8:0]  splo9;
   logic [4:0]  sph5;
   logic        daa_c;
   logic        daa_lo;
   logic [7:0]  daa_corr;
   logic [7:0]  daa_r;
   logic [8:0]  cb_sh9;
   logic [8:0]  a_sh9;
   logic [7:0]  bit_mask;
   logic        is_alu;
   logic        is_low;
   caf_pkg::alu_op_type alu_sel;

   assign op   = req.opcode;
   assign acc  = req.acc;
   assign opnd = req.operand;
   assign cin  = req.flags_in[caf_pkg::FLAG_C];
   assign cuse = cin & op[3] & ~op[5];

   assign add9  = {1'b0, acc} + {1'b0, opnd} + {8'd0, cuse};
   assign addh5 = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]} + {4'd0, cuse};
   assign sub9  = {1'b0, acc} - {1'b0, opnd} - {8'd0, cuse};
   assign subh5 = {1'b0, acc[3:0]} - {1'b0, opnd[3:0]} - {4'd0, cuse};
   assign and8  = acc & opnd;
   assign xor8  = acc ^ opnd;
   assign or8   = acc | opnd;
   assign inc8  = opnd + 8'd1;
   assign dec8  = opnd - 8'd1;

   assign hl17  = {1'b0, req.wide_a} + {1'b0, req.wide_b};
   assign hl13  = {1'b0, req.wide_a[11:0]} + {1'b0, req.wide_b[11:0]};
   assign sp16  = req.wide_a + {{8{opnd[7]}}, opnd};
   assign splo9 = {1'b0, req.wide_a[7:0]} + {1'b0, opnd};
   assign sph5  = {1'b0, req.wide_a[3:0]} + {1'b0, opnd[3:0]};

   assign daa_c    = cin | (~req.flags_in[caf_pkg::FLAG_N] & (acc > caf_pkg::DAA_LIMIT));
   assign daa_lo   = req.flags_in[caf_pkg::FLAG_H]
                   | (~req.flags_in[caf_pkg::FLAG_N] & (acc[3:0] > caf_pkg::DIGIT_MAX));
   assign daa_corr = (daa_c ? caf_pkg::DAA_HI_ADJ : 8'h00)
                   | (daa_lo ? caf_pkg::DAA_LO_ADJ : 8'h00);
   assign daa_r    = req.flags_in[caf_pkg::FLAG_N] ? (acc - daa_corr) : (acc + daa_corr);

   assign cb_sh9   = caf_pkg::shift8(caf_pkg::shift_op_type'(op[5:3]), opnd, cin);
   assign a_sh9    = caf_pkg::shift8(caf_pkg::shift_op_type'(op[5:3]), acc, cin);
   assign bit_mask = 8'h01 << op[5:3];

   assign alu_sel = caf_pkg::alu_op_type'(op[5:3]);
   assign is_alu  = (op[7:6] == caf_pkg::PAGE_ALU_REG)
                  || ((op & caf_pkg::MASK_GROUP) == caf_pkg::CODE_ALU_IMM);
   assign is_low  = (op[7:6] == caf_pkg::PAGE_LOW);

   always_comb begin
      rsp.result        = acc;
      rsp.wide_result   = req.wide_a;
      rsp.flags_out     = req.flags_in;
      rsp.writes_result = 1'b0;
      rsp.supported     = 1'b1;
      if (req.prefixed) begin
         case (caf_pkg::cb_mode_type'(op[7:6]))
            caf_pkg::CB_SHIFT: begin
               rsp.result        = cb_sh9[7:0];
               rsp.flags_out     = {cb_sh9[7:0] == 8'd0, 1'b0, 1'b0, cb_sh9[8]};
               rsp.writes_result = 1'b1;
            end
            caf_pkg::CB_BIT: begin
               rsp.flags_out = {~|(opnd & bit_mask), 1'b0, 1'b1, cin};
            end
            caf_pkg::CB_RES: begin
               rsp.result        = opnd & ~bit_mask;
               rsp.writes_result = 1'b1;
            end
            caf_pkg::CB_SET: begin
               rsp.result        = opnd | bit_mask;
               rsp.writes_result = 1'b1;
            end
            default: begin
               rsp.supported = 1'b0;
            end
         endcase
      end else if (is_alu) begin
         rsp.writes_result = 1'b1;
         case (alu_sel)
            caf_pkg::ALU_ADD, caf_pkg::ALU_ADC: begin
               rsp.result    = add9[7:0];
               rsp.flags_out = {add9[7:0] == 8'd0, 1'b0, addh5[4], add9[8]};
            end
            caf_pkg::ALU_SUB, caf_pkg::ALU_SBC: begin
               rsp.result    = sub9[7:0];
               rsp.flags_out = {sub9[7:0] == 8'd0, 1'b1, subh5[4], sub9[8]};
            end
            caf_pkg::ALU_AND: begin
               rsp.result    = and8;
               rsp.flags_out = {and8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            caf_pkg::ALU_XOR: begin
               rsp.result    = xor8;
               rsp.flags_out = {xor8 == 8'd0, 3'b000};
            end
            caf_pkg::ALU_OR: begin
               rsp.result    = or8;
               rsp.flags_out = {or8 == 8'd0, 3'b000};
            end
            caf_pkg::ALU_CP: begin
               rsp.flags_out     = {sub9[7:0] == 8'd0, 1'b1, subh5[4], sub9[8]};
               rsp.writes_result = 1'b0;
            end
            default: begin
               rsp.writes_result = 1'b0;
            end
         endcase
      end else if (is_low && ((op & caf_pkg::MASK_GROUP) == caf_pkg::CODE_INC)) begin
         rsp.result        = inc8;
         rsp.flags_out     = {inc8 == 8'd0, 1'b0, opnd[3:0] == 4'hF, cin};
         rsp.writes_result = 1'b1;
      end else if (is_low && ((op & caf_pkg::MASK_GROUP) == caf_pkg::CODE_DEC)) begin
         rsp.result        = dec8;
         rsp.flags_out     = {dec8 == 8'd0, 1'b1, opnd[3:0] == 4'h0, cin};
         rsp.writes_result = 1'b1;
      end else if ((op & caf_pkg::MASK_PAIR) == caf_pkg::CODE_ADD_HL) begin
         rsp.wide_result   = hl17[15:0];
         rsp.flags_out     = {req.flags_in[caf_pkg::FLAG_Z], 1'b0, hl13[12], hl17[16]};
         rsp.writes_result = 1'b1;
      end else if (op == caf_pkg::OP_ADD_SP || op == caf_pkg::OP_LD_HL_SP) begin
         rsp.wide_result   = sp16;
         rsp.flags_out     = {1'b0, 1'b0, sph5[4], splo9[8]};
         rsp.writes_result = 1'b1;
      end else if (op == caf_pkg::OP_DAA) begin
         rsp.result        = daa_r;
         rsp.flags_out     = {daa_r == 8'd0, req.flags_in[caf_pkg::FLAG_N], 1'b0, daa_c};
         rsp.writes_result = 1'b1;
      end else if (op == caf_pkg::OP_CPL) begin
         rsp.result        = ~acc;
         rsp.flags_out     = {req.flags_in[caf_pkg::FLAG_Z], 1'b1, 1'b1, cin};
         rsp.writes_result = 1'b1;
      end else if (op == caf_pkg::OP_SCF) begin
         rsp.flags_out = {req.flags_in[caf_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
      end else if (op == caf_pkg::OP_CCF) begin
         rsp.flags_out = {req.flags_in[caf_pkg::FLAG_Z], 1'b0, 1'b0, ~cin};
      end else if (op == caf_pkg::OP_RLCA || op == caf_pkg::OP_RRCA
                   || op == caf_pkg::OP_RLA || op == caf_pkg::OP_RRA) begin
         rsp.result        = a_sh9[7:0];
         rsp.flags_out     = {3'b000, a_sh9[8]};
         rsp.writes_result = 1'b1;
      end else begin
         rsp.supported = 1'b0;
      end
   end

endmodule

### design/cpu_alu_flag_unit.sv
// Top level of the ALU and flag unit: request register, execute logic, response register.
// Depends on caf_pkg, caf_if, caf_exec and cpu_alu_flag_unit_defines.svh.
`timescale 1ns / 1ps
`include "cpu_alu_flag_unit_defines.svh"

// Takes one opcode beat per cycle while req_if.ready is high, plain or CB page, and returns
// one response beat with the new byte, the 16-bit sum and the Z N H C flags. A beat enters
// the request register, passes the execute logic and lands in the response register, whose
// valid bit drives rsp_if.valid; one beat per cycle is sustained as long as rsp_if.ready
// stays high. A stall on the response side fills both registers before req_if.ready
// drops. No state beyond the two pipeline registers; reset only empties them.
module cpu_alu_flag_unit (
   input  logic       clock,
   input  logic       reset,
   caf_req_if.sink    req_if,
   caf_rsp_if.source  rsp_if
);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   caf_pkg::req_type s1_req_ff;
   caf_pkg::req_type s1_req_in;
   logic             s2_valid_ff;
   logic             s2_valid_in;
   caf_pkg::rsp_type s2_rsp_ff;
   caf_pkg::rsp_type s2_rsp_in;
   caf_pkg::rsp_type exec_rsp;
   logic             s1_ready;
   logic             s2_ready;
   logic             req_beat;
   logic             rsp_unsup;

   assign s2_ready     = ~s2_valid_ff | rsp_if.ready;
   assign s1_ready     = ~s1_valid_ff | s2_ready;
   assign req_if.ready = s1_ready;
   assign req_beat     = req_if.valid & s1_ready;

   assign s1_req_in = '{opcode:   req_if.opcode,
                        prefixed: req_if.prefixed,
                        acc:      req_if.acc,
                        operand:  req_if.operand,
                        wide_a:   req_if.wide_a,
                        wide_b:   req_if.wide_b,
                        flags_in: req_if.flags_in};

   caf_exec u_exec (
      .req (s1_req_ff),
      .rsp (exec_rsp)
   );

   always_comb begin
      s1_valid_in = s1_ready ? req_if.valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_rsp_in   = exec_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_req_ff <= s1_req_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_rsp_ff <= s2_rsp_in;
      end
   end

   assign rsp_if.valid         = s2_valid_ff;
   assign rsp_if.result        = s2_rsp_ff.result;
   assign rsp_if.wide_result   = s2_rsp_ff.wide_result;
   assign rsp_if.flags_out     = s2_rsp_ff.flags_out;
   assign rsp_if.writes_result = s2_rsp_ff.writes_result;
   assign rsp_if.supported     = s2_rsp_ff.supported;

   assign rsp_unsup = s2_valid_ff & ~s2_rsp_ff.supported;

   `CAF_ASSERT_NEXT(a_req_lands, clock, reset, req_beat, s1_valid_ff, "beat lost on entry")
   `CAF_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s2_ready, s1_valid_ff, "stall lost")
   `CAF_ASSERT_NEXT(a_s2_fills, clock, reset, s1_valid_ff && s2_ready, s2_valid_ff, "beat lost")
   `CAF_ASSERT_NOW(a_unsup_wr, clock, reset, rsp_unsup, !rsp_if.writes_result, "bad write")

endmodule
